FILE: rtl/kmle_pkg.sv
// kmle_pkg: shared types, codes and sizing constants of the k-mutex lamport engine
// depends on nothing; used by k_mutex_lamport_engine_core
package kmle_pkg;

   // sizing
   localparam int MAX_NODES   = 64;
   localparam int DEFER_DEPTH = 64;
   localparam int CLOCK_BITS  = 32;
   localparam int MAX_OUT     = 64;

   localparam int NODE_W  = 6;
   localparam int CNT_W   = 7;
   localparam int MSG_W   = 32;
   localparam int PTR_W   = $clog2(DEFER_DEPTH);
   localparam int FILL_W  = $clog2(DEFER_DEPTH + 1);
   localparam int DRAIN_W = $clog2(MAX_OUT + 1);
   localparam int ENTRY_W = NODE_W + MSG_W;

   // stream packing
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 3;

   typedef logic [CLOCK_BITS-1:0] clk_type;
   typedef logic [MAX_NODES-1:0]  map_type;

   // input operations
   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_REPLY   = 2'd1,
      OP_START   = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_REPLY     = 2'd0,
      KIND_BROADCAST = 2'd1,
      KIND_GRANT     = 2'd2,
      KIND_UNUSED    = 2'd3
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_NODE_ID    = 2'd0,
      CSR_NODE_COUNT = 2'd1,
      CSR_CAPACITY   = 2'd2,
      CSR_NONE       = 2'd3
   } csr_type;

   // protocol phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_REQ  = 3'b010,
      PH_HOLD = 3'b100
   } phase_type;

   // sequencer
   typedef enum logic [3:0] {
      ST_READY = 4'b0001,
      ST_GRANT = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   // grant once fewer than capacity peers are still unmarked (signed test)
   function automatic logic grant_ok(input logic [CNT_W-1:0] node_count,
                                     input logic [CNT_W-1:0] marked,
                                     input logic [CNT_W-1:0] capacity);
      logic signed [CNT_W+1:0] unmarked;
      unmarked = $signed({2'b00, node_count}) - $signed((CNT_W+2)'(1))
                 - $signed({2'b00, marked});
      return unmarked < $signed({2'b00, capacity});
   endfunction

endpackage

FILE: rtl/k_mutex_lamport_engine_core.sv
// k_mutex_lamport_engine_core: one node of k-of-n mutual exclusion under lamport clocks
// deferred requests live in a synchronous stack memory; depends on kmle_pkg
//
// timing: a result is registered and on rsp in the cycle after its input transfer; a second result
// (grant notice) follows in the cycle after the first is taken.
// rate: one input per cycle while results are taken and no grant notice or drain is under way;
// a release drains the deferred stack one reply at a time (stack memory read, then output load).
// reset: synchronous, clears phase, clock, marks, stack fill and config to defaults.
module k_mutex_lamport_engine_core (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kmle_pkg::REQ_DATA_W-1:0] req_tdata,  // sender, msg_clock, msg_id, zero pad
   input  logic [kmle_pkg::REQ_USER_W-1:0] req_tuser,  // operation
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kmle_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_dest, out_clock, out_id, zero pad
   output logic [kmle_pkg::RSP_USER_W-1:0] rsp_tuser,  // out_kind, overflow
   output logic                           rsp_tlast,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [kmle_pkg::CNT_W-1:0]     csr_data
);

   // configuration registers
   logic [kmle_pkg::NODE_W-1:0] node_id_ff;
   logic [kmle_pkg::CNT_W-1:0]  node_count_ff;
   logic [kmle_pkg::CNT_W-1:0]  capacity_ff;

   // engine state
   kmle_pkg::phase_type         phase_ff, phase_in;
   kmle_pkg::state_type         st_ff, st_in;
   kmle_pkg::clk_type           clock_ff, clock_in;
   kmle_pkg::clk_type           own_ff, own_in;
   kmle_pkg::map_type           accept_map_ff, accept_map_in;
   logic [kmle_pkg::CNT_W-1:0]  accept_cnt_ff, accept_cnt_in;
   logic [kmle_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [kmle_pkg::DRAIN_W-1:0] drain_cnt_ff, drain_cnt_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   kmle_pkg::kind_type          rsp_kind_ff, rsp_kind_in;
   logic [kmle_pkg::NODE_W-1:0] rsp_dest_ff, rsp_dest_in;
   logic [kmle_pkg::MSG_W-1:0]  rsp_clock_ff, rsp_clock_in;
   logic [kmle_pkg::MSG_W-1:0]  rsp_id_ff, rsp_id_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        rsp_last_ff, rsp_last_in;

   // deferred stack memory
   logic [kmle_pkg::ENTRY_W-1:0] stack_mem [kmle_pkg::DEFER_DEPTH];
   logic [kmle_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [kmle_pkg::PTR_W-1:0]   rd_addr;
   logic                         push;

   // decoded input
   kmle_pkg::op_type            op;
   logic [kmle_pkg::NODE_W-1:0] sender;
   kmle_pkg::clk_type           mclk;
   logic [kmle_pkg::MSG_W-1:0]  mid;
   kmle_pkg::clk_type           clk_max;
   kmle_pkg::clk_type           clk_rx;
   kmle_pkg::clk_type           clk_start;
   logic                        req_fire;
   logic                        out_free;
   logic                        is_lower;
   logic                        can_mark;
   logic [kmle_pkg::CNT_W-1:0]  cnt_marked;
   logic                        stack_full;
   logic                        drain_last;

   assign op     = kmle_pkg::op_type'(req_tuser[1:0]);
   assign sender = req_tdata[5:0];
   assign mclk   = kmle_pkg::clk_type'(req_tdata[37:6]);
   assign mid    = req_tdata[69:38];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (st_ff == kmle_pkg::ST_READY) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // lamport update on receipt and on start
   assign clk_max   = (clock_ff > mclk) ? clock_ff : mclk;
   assign clk_rx    = clk_max + kmle_pkg::clk_type'(1);
   assign clk_start = clock_ff + kmle_pkg::clk_type'(1);

   // priority and marking of the sender
   assign is_lower   = (own_ff < mclk) || ((own_ff == mclk) && (sender > node_id_ff));
   assign can_mark   = (sender != node_id_ff) && ({1'b0, sender} < node_count_ff)
                       && !accept_map_ff[sender];
   assign cnt_marked = can_mark ? accept_cnt_ff + kmle_pkg::CNT_W'(1) : accept_cnt_ff;
   assign stack_full = (fill_ff == kmle_pkg::FILL_W'(kmle_pkg::DEFER_DEPTH));
   assign drain_last = (fill_ff == '0) || (drain_cnt_ff == kmle_pkg::DRAIN_W'(kmle_pkg::MAX_OUT));

   // next state and result selection
   always_comb begin
      phase_in      = phase_ff;
      st_in         = st_ff;
      clock_in      = clock_ff;
      own_in        = own_ff;
      accept_map_in = accept_map_ff;
      accept_cnt_in = accept_cnt_ff;
      fill_in       = fill_ff;
      drain_cnt_in  = drain_cnt_ff;
      push          = 1'b0;
      rd_addr       = kmle_pkg::PTR_W'(fill_ff - kmle_pkg::FILL_W'(1));
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_clock_in  = rsp_clock_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      case (st_ff)
         kmle_pkg::ST_READY: begin
            if (req_fire) begin
               case (op)
                  kmle_pkg::OP_REQUEST: begin
                     clock_in     = clk_rx;
                     rsp_kind_in  = kmle_pkg::KIND_REPLY;
                     rsp_dest_in  = sender;
                     rsp_clock_in = kmle_pkg::MSG_W'(clk_rx);
                     rsp_id_in    = mid;
                     rsp_ovf_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                     if (phase_ff == kmle_pkg::PH_IDLE ||
                         (phase_ff == kmle_pkg::PH_REQ && !is_lower)) begin
                        // answer at once
                        rsp_valid_in = 1'b1;
                     end else begin
                        // defer, or flag a lost deferral
                        if (stack_full) begin
                           rsp_valid_in = 1'b1;
                           rsp_ovf_in   = 1'b1;
                        end else begin
                           push    = 1'b1;
                           fill_in = fill_ff + kmle_pkg::FILL_W'(1);
                        end
                        if (phase_ff == kmle_pkg::PH_REQ) begin
                           if (can_mark) begin
                              accept_map_in = accept_map_ff
                                              | (kmle_pkg::map_type'(1) << sender);
                              accept_cnt_in = cnt_marked;
                           end
                           if (kmle_pkg::grant_ok(node_count_ff, cnt_marked, capacity_ff)) begin
                              phase_in = kmle_pkg::PH_HOLD;
                              if (stack_full) begin
                                 rsp_last_in = 1'b0;
                                 st_in       = kmle_pkg::ST_GRANT;
                              end else begin
                                 rsp_valid_in = 1'b1;
                                 rsp_kind_in  = kmle_pkg::KIND_GRANT;
                                 rsp_dest_in  = '0;
                                 rsp_id_in    = kmle_pkg::MSG_W'(own_ff);
                              end
                           end
                        end
                     end
                  end
                  kmle_pkg::OP_REPLY: begin
                     clock_in = clk_rx;
                     if (phase_ff == kmle_pkg::PH_REQ && mid == kmle_pkg::MSG_W'(own_ff)) begin
                        if (can_mark) begin
                           accept_map_in = accept_map_ff | (kmle_pkg::map_type'(1) << sender);
                           accept_cnt_in = cnt_marked;
                        end
                        if (kmle_pkg::grant_ok(node_count_ff, cnt_marked, capacity_ff)) begin
                           phase_in     = kmle_pkg::PH_HOLD;
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = kmle_pkg::KIND_GRANT;
                           rsp_dest_in  = '0;
                           rsp_clock_in = kmle_pkg::MSG_W'(clk_rx);
                           rsp_id_in    = kmle_pkg::MSG_W'(own_ff);
                           rsp_ovf_in   = 1'b0;
                           rsp_last_in  = 1'b1;
                        end
                     end
                  end
                  kmle_pkg::OP_START: begin
                     if (phase_ff == kmle_pkg::PH_IDLE) begin
                        clock_in      = clk_start;
                        own_in        = clk_start;
                        accept_map_in = '0;
                        accept_cnt_in = '0;
                        phase_in      = kmle_pkg::PH_REQ;
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = kmle_pkg::KIND_BROADCAST;
                        rsp_dest_in   = '0;
                        rsp_clock_in  = kmle_pkg::MSG_W'(clk_start);
                        rsp_id_in     = kmle_pkg::MSG_W'(clk_start);
                        rsp_ovf_in    = 1'b0;
                        rsp_last_in   = 1'b1;
                        // immediate grant when capacity covers the peers
                        if (kmle_pkg::grant_ok(node_count_ff, '0, capacity_ff)) begin
                           phase_in    = kmle_pkg::PH_HOLD;
                           rsp_last_in = 1'b0;
                           st_in       = kmle_pkg::ST_GRANT;
                        end
                     end
                  end
                  kmle_pkg::OP_RELEASE: begin
                     if (phase_ff == kmle_pkg::PH_HOLD) begin
                        if (fill_ff == '0) begin
                           phase_in = kmle_pkg::PH_IDLE;
                        end else begin
                           drain_cnt_in = '0;
                           st_in        = kmle_pkg::ST_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // second result of an item: the grant notice
         kmle_pkg::ST_GRANT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kmle_pkg::KIND_GRANT;
               rsp_dest_in  = '0;
               rsp_clock_in = kmle_pkg::MSG_W'(clock_ff);
               rsp_id_in    = kmle_pkg::MSG_W'(own_ff);
               rsp_ovf_in   = 1'b0;
               rsp_last_in  = 1'b1;
               st_in        = kmle_pkg::ST_READY;
            end
         end
         // pop: read the top entry
         kmle_pkg::ST_READ: begin
            fill_in      = fill_ff - kmle_pkg::FILL_W'(1);
            drain_cnt_in = drain_cnt_ff + kmle_pkg::DRAIN_W'(1);
            st_in        = kmle_pkg::ST_SEND;
         end
         // pop: send the reply that was read
         kmle_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kmle_pkg::KIND_REPLY;
               rsp_dest_in  = rd_data_ff[kmle_pkg::NODE_W-1:0];
               rsp_clock_in = kmle_pkg::MSG_W'(clock_ff);
               rsp_id_in    = rd_data_ff[kmle_pkg::ENTRY_W-1:kmle_pkg::NODE_W];
               rsp_ovf_in   = 1'b0;
               rsp_last_in  = drain_last;
               if (drain_last) begin
                  st_in = kmle_pkg::ST_READY;
                  if (fill_ff == '0) begin
                     phase_in = kmle_pkg::PH_IDLE;
                  end
               end else begin
                  st_in = kmle_pkg::ST_READ;
               end
            end
         end
         default: begin
            st_in = kmle_pkg::ST_READY;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff    <= '0;
         node_count_ff <= kmle_pkg::CNT_W'(2);
         capacity_ff   <= kmle_pkg::CNT_W'(1);
         phase_ff      <= kmle_pkg::PH_IDLE;
         st_ff         <= kmle_pkg::ST_READY;
         clock_ff      <= '0;
         own_ff        <= '0;
         accept_map_ff <= '0;
         accept_cnt_ff <= '0;
         fill_ff       <= '0;
         drain_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (kmle_pkg::csr_type'(csr_index))
               kmle_pkg::CSR_NODE_ID:    node_id_ff    <= csr_data[kmle_pkg::NODE_W-1:0];
               kmle_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data;
               kmle_pkg::CSR_CAPACITY:   capacity_ff   <= csr_data;
               default: begin
               end
            endcase
         end
         phase_ff      <= phase_in;
         st_ff         <= st_in;
         clock_ff      <= clock_in;
         own_ff        <= own_in;
         accept_map_ff <= accept_map_in;
         accept_cnt_ff <= accept_cnt_in;
         fill_ff       <= fill_in;
         drain_cnt_ff  <= drain_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_clock_ff <= rsp_clock_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // stack memory: push on defer, registered read on pop
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[fill_ff[kmle_pkg::PTR_W-1:0]] <= {mid, sender};
      end
      if (st_ff == kmle_pkg::ST_READ) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // stream outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_id_ff, rsp_clock_ff, rsp_dest_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= kmle_pkg::FILL_W'(kmle_pkg::DEFER_DEPTH))
      else $error("stack fill beyond depth");

   a_count_map: assert property (@(posedge clock) disable iff (reset)
      accept_cnt_ff == kmle_pkg::CNT_W'($countones(accept_map_ff)))
      else $error("accept count out of step with accept map");

   a_drain_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == kmle_pkg::ST_READ || st_ff == kmle_pkg::ST_SEND || st_ff == kmle_pkg::ST_GRANT)
      |-> phase_ff == kmle_pkg::PH_HOLD)
      else $error("drain or grant outside holding");

   a_grant_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && rsp_kind_ff == kmle_pkg::KIND_GRANT)
      |-> phase_ff == kmle_pkg::PH_HOLD)
      else $error("grant transfer while not holding");

   a_drain_limit: assert property (@(posedge clock) disable iff (reset)
      drain_cnt_ff <= kmle_pkg::DRAIN_W'(kmle_pkg::MAX_OUT))
      else $error("drain count beyond limit");

endmodule
